FILE: design/utf8f_pkg.sv
// ----------------------------------------------------------------------------
// utf8f_pkg
// Shared types, constants and the byte classification/scan function for the
// UTF-8 alphanumeric and CJK byte filter.
// ----------------------------------------------------------------------------
package utf8f_pkg;

    // Lead byte range of the kept three-byte sequences
    localparam logic [7:0] LEAD_LO    = 8'd228;
    localparam logic [7:0] LEAD_HI    = 8'd233;
    // Trail byte limits
    localparam logic [7:0] TRAIL_LO   = 8'd128;
    localparam logic [7:0] TRAIL_HI   = 8'd191;
    localparam logic [7:0] T1_LO_228  = 8'd184;
    localparam logic [7:0] T1_HI_233  = 8'd190;
    localparam logic [7:0] T2_HI_233  = 8'd165;

    // Group queue between front and back
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    // Results caused by one input byte
    typedef struct packed {
        logic [2:0][7:0] bytes;    // kept bytes, entry 0 first
        logic [1:0]      cnt;      // number of results, 1..3
        logic            vld;      // bytes are real (0 for the end marker)
        logic            last;     // group closes the text
    } t_group;

    // Outcome of scanning pending bytes plus one new byte
    typedef struct packed {
        logic [1:0]      n_out;
        logic [2:0][7:0] out;
        logic [1:0]      pend_cnt;
        logic [7:0]      pend0;
        logic [7:0]      pend1;
    } t_scan;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'd48 && c <= 8'd57) || (c >= 8'd65 && c <= 8'd90) ||
               (c >= 8'd97 && c <= 8'd122);
    endfunction

    function automatic logic is_lead(input logic [7:0] c);
        return c >= LEAD_LO && c <= LEAD_HI;
    endfunction

    function automatic logic trails_fit(input logic [7:0] lead,
                                        input logic [7:0] t1,
                                        input logic [7:0] t2);
        logic [7:0] lo1;
        logic [7:0] hi1;
        logic [7:0] hi2;
        lo1 = TRAIL_LO;
        hi1 = TRAIL_HI;
        hi2 = TRAIL_HI;
        if (lead == LEAD_LO) begin
            lo1 = T1_LO_228;
        end else if (lead == LEAD_HI) begin
            hi1 = T1_HI_233;
            hi2 = T2_HI_233;
        end
        return t1 >= lo1 && t1 <= hi1 && t2 >= TRAIL_LO && t2 <= hi2;
    endfunction

    // Scan up to three bytes: pending lookahead then the new byte
    function automatic t_scan scan(input logic [1:0] cnt,
                                   input logic [7:0] p0,
                                   input logic [7:0] p1,
                                   input logic [7:0] b,
                                   input logic       last);
        t_scan           r;
        logic [2:0][7:0] q;
        logic [1:0]      n;
        logic [1:0]      pos;
        logic [1:0]      avail;
        logic [1:0]      k;
        logic            stop;
        logic [7:0]      s;
        r     = '0;
        q     = '0;
        k     = 2'd0;
        pos   = 2'd0;
        stop  = 1'b0;
        // Build the work queue; an out-of-range count reads as two
        case (cnt)
            2'd0: begin
                q[0] = b;
                n    = 2'd1;
            end
            2'd1: begin
                q[0] = p0;
                q[1] = b;
                n    = 2'd2;
            end
            default: begin
                q[0] = p0;
                q[1] = p1;
                q[2] = b;
                n    = 2'd3;
            end
        endcase
        // Each pass advances at least one byte or stops
        for (int i = 0; i < 3; i++) begin
            if (!stop && pos < n) begin
                s     = q[pos];
                avail = n - pos;
                if (is_alnum(s)) begin
                    r.out[k] = s;
                    k        = k + 2'd1;
                    pos      = pos + 2'd1;
                end else if (is_lead(s)) begin
                    if (avail == 2'd3) begin
                        if (trails_fit(s, q[1], q[2])) begin
                            r.out[0] = q[0];
                            r.out[1] = q[1];
                            r.out[2] = q[2];
                            k        = 2'd3;
                            pos      = 2'd3;
                        end else begin
                            pos = pos + 2'd1;
                        end
                    end else if (last) begin
                        pos = pos + 2'd1;
                    end else begin
                        stop = 1'b1;
                    end
                end else begin
                    pos = pos + 2'd1;
                end
            end
        end
        r.n_out    = k;
        r.pend_cnt = last ? 2'd0 : (n - pos);
        case (pos)
            2'd0: begin
                r.pend0 = q[0];
                r.pend1 = q[1];
            end
            2'd1: begin
                r.pend0 = q[1];
                r.pend1 = q[2];
            end
            default: begin
                r.pend0 = q[2];
                r.pend1 = q[2];
            end
        endcase
        return r;
    endfunction

endpackage

FILE: design/utf8f_front.sv
// ----------------------------------------------------------------------------
// utf8f_front
// Accepts one byte per cycle while the queue is not full, scans it against the
// lookahead bytes and pushes the group of results it causes into the queue.
// ----------------------------------------------------------------------------
module utf8f_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_in_byte,
    input  logic                i_text_last,
    input  logic                i_q_full,
    output logic                o_push,
    output utf8f_pkg::t_group   o_group
);
    import utf8f_pkg::*;

    logic [1:0] r_pend_cnt;
    logic [7:0] r_pend0;
    logic [7:0] r_pend1;
    t_scan      w_scan;
    logic       w_accept;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;

    // Classify the new byte together with the lookahead
    always_comb begin
        w_scan = scan(r_pend_cnt, r_pend0, r_pend1, i_in_byte, i_text_last);
    end

    // Build the group; an empty last step yields the end marker
    always_comb begin
        o_group.bytes = w_scan.out;
        o_group.last  = i_text_last;
        if (w_scan.n_out == 2'd0) begin
            o_group.cnt = 2'd1;
            o_group.vld = 1'b0;
        end else begin
            o_group.cnt = w_scan.n_out;
            o_group.vld = 1'b1;
        end
        o_push = w_accept && (w_scan.n_out != 2'd0 || i_text_last);
    end

    // Hold the lookahead count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_cnt <= 2'd0;
        end else if (w_accept) begin
            r_pend_cnt <= w_scan.pend_cnt;
        end
    end

    // Hold the lookahead bytes
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pend0 <= w_scan.pend0;
            r_pend1 <= w_scan.pend1;
        end
    end

endmodule

FILE: design/utf8f_queue.sv
// ----------------------------------------------------------------------------
// utf8f_queue
// Short queue of result groups between the front and the back.
// ----------------------------------------------------------------------------
module utf8f_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  utf8f_pkg::t_group   i_group,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_nonempty,
    output utf8f_pkg::t_group   o_head
);
    import utf8f_pkg::*;

    t_group                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_AW:0]     r_count;

    assign o_full     = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd_ptr];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QUEUE_AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (QUEUE_AW+1)'(1);
            end
        end
    end

    // Store pushed groups
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

endmodule

FILE: design/utf8f_back.sv
// ----------------------------------------------------------------------------
// utf8f_back
// Walks the head group one result per unstalled cycle to the output register.
// ----------------------------------------------------------------------------
module utf8f_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_nonempty,
    input  utf8f_pkg::t_group   i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_out_byte,
    output logic                o_byte_valid,
    output logic                o_run_last,
    output logic                o_text_end
);
    import utf8f_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_bvalid;
    logic       r_run_last;
    logic       r_text_end;
    logic       w_load;
    logic       w_take;
    logic       w_grp_end;

    assign w_load    = !r_valid || i_ready;
    assign w_take    = w_load && i_nonempty;
    assign w_grp_end = (r_idx == i_head.cnt - 2'd1);
    assign o_pop     = w_take && w_grp_end;

    assign o_valid      = r_valid;
    assign o_out_byte   = r_byte;
    assign o_byte_valid = r_bvalid;
    assign o_run_last   = r_run_last;
    assign o_text_end   = r_text_end;

    // Advance the result index and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_idx <= w_grp_end ? 2'd0 : r_idx + 2'd1;
            end
            if (w_load) begin
                r_valid <= i_nonempty;
            end
        end
    end

    // Load the output payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byte     <= i_head.vld ? i_head.bytes[r_idx] : 8'd0;
            r_bvalid   <= i_head.vld;
            r_run_last <= w_grp_end;
            r_text_end <= w_grp_end && i_head.last;
        end
    end

endmodule

FILE: design/utf8_alnum_cjk_filter_top.sv
// ----------------------------------------------------------------------------
// utf8_alnum_cjk_filter_top
// UTF-8 byte filter that keeps ASCII digits, letters and CJK three-byte
// sequences, and marks the last result of each input and of each text.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle. Each byte is scanned in the cycle it is
// taken against up to two held lookahead bytes and yields zero to three
// results (one end marker when a text ends with nothing kept). Results leave
// one per cycle, while i_ready allows, through a registered output, so a byte
// that completes a three-byte sequence holds the output for its three results;
// a two-group queue between the scanner and the output lets input continue
// meanwhile, and the input stalls only when that queue is full. A byte reaches
// the output through the queue and the output register.
module utf8_alnum_cjk_filter_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_text_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_run_last,
    output logic       o_text_end
);
    import utf8f_pkg::*;

    t_group w_push_group;
    t_group w_head;
    logic   w_push;
    logic   w_full;
    logic   w_pop;
    logic   w_nonempty;

    // Scan and classify input bytes
    utf8f_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in_byte   (i_in_byte),
        .i_text_last (i_text_last),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_group     (w_push_group)
    );

    // Buffer result groups
    utf8f_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_group    (w_push_group),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_nonempty (w_nonempty),
        .o_head     (w_head)
    );

    // Deliver results one per transfer
    utf8f_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_nonempty   (w_nonempty),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_run_last   (o_run_last),
        .o_text_end   (o_text_end)
    );

endmodule
